@@ hdl/vdi_pkg.sv @@
// ----------------------------------------------------------------------------
// vdi_pkg
// shared types, sizes and helpers of the vertex dedup indexer
// ----------------------------------------------------------------------------
package vdi_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_WORDS    = 8;
    localparam int WORD_W       = 32;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int VTX_W        = MAX_WORDS * WORD_W;
    localparam int NW_W         = 4;
    localparam int POS_W        = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_VERTICES);
    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
    localparam logic [NW_W-1:0]  NW_RESET  = NW_W'(8);

    typedef logic [MAX_WORDS-1:0][WORD_W-1:0] t_vertex;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // register value of zero acts as one, above the maximum acts as the maximum
    function automatic logic [NW_W-1:0] active_words(input logic [NW_W-1:0] cfg);
        logic [NW_W-1:0] n;
        n = cfg;
        if (n == '0) begin
            n = NW_W'(1);
        end
        if (n > NW_W'(MAX_WORDS)) begin
            n = NW_W'(MAX_WORDS);
        end
        return n;
    endfunction

endpackage

@@ hdl/vertex_dedup_indexer.sv @@
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// requests: o_stall is high outside idle, so a new request is taken only
// after the last result is loaded; the scan is bound by the single
//   store read port scanning one stored vertex per cycle, lowest index first
// reset: synchronous, clears counts and sets words_in_use to 8; store
//   contents are left as is, only entries below the count are read
// ----------------------------------------------------------------------------
module vertex_dedup_indexer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_words_in_use_we,
    input  logic [vdi_pkg::NW_W-1:0]      i_words_in_use,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [vdi_pkg::WORD_W-1:0]    i_vertex_word_0,
    input  logic [vdi_pkg::WORD_W-1:0]    i_vertex_word_1,
    input  logic [vdi_pkg::WORD_W-1:0]    i_vertex_word_2,
    input  logic [vdi_pkg::WORD_W-1:0]    i_vertex_word_3,
    input  logic [vdi_pkg::WORD_W-1:0]    i_vertex_word_4,
    input  logic [vdi_pkg::WORD_W-1:0]    i_vertex_word_5,
    input  logic [vdi_pkg::WORD_W-1:0]    i_vertex_word_6,
    input  logic [vdi_pkg::WORD_W-1:0]    i_vertex_word_7,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [vdi_pkg::IDX_W-1:0]     o_vertex_index,
    output logic                          o_was_new,
    output logic                          o_table_full,
    output logic [vdi_pkg::POS_W-1:0]     o_list_position
);
    import vdi_pkg::*;

    t_state             r_state, n_state;
    logic [NW_W-1:0]    r_words_in_use;
    logic [NW_W-1:0]    r_n;
    t_vertex            r_vtx;
    logic [CNT_W-1:0]   r_count;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_scan;
    logic               r_rd_pend;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;

    logic               r_ov;
    logic [IDX_W-1:0]   r_o_index;
    logic               r_o_new;
    logic               r_o_full;
    logic [POS_W-1:0]   r_o_pos;

    t_vertex            w_in_vtx;
    t_vertex            w_rd_vtx;
    logic [VTX_W-1:0]   w_rdata;
    logic [NW_W-1:0]    w_n;
    logic               w_accept;
    logic               w_match;
    logic               w_hit_now;
    logic               w_more;
    logic               w_out_free;
    logic               w_re;
    logic               w_we;
    logic               w_load;
    logic               w_full;

    assign w_in_vtx = {i_vertex_word_7, i_vertex_word_6, i_vertex_word_5, i_vertex_word_4,
                       i_vertex_word_3, i_vertex_word_2, i_vertex_word_1, i_vertex_word_0};
    assign w_n        = active_words(r_words_in_use);
    assign w_accept   = i_valid && !o_stall;
    assign w_rd_vtx   = t_vertex'(w_rdata);
    assign w_hit_now  = r_rd_pend && w_match;
    assign w_more     = r_scan < r_count;
    assign w_out_free = !r_ov || !i_stall;
    assign w_full     = !r_hit && (r_count == COUNT_MAX);

    vdi_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (VTX_W'(r_vtx)),
        .i_re    (w_re),
        .i_raddr (r_scan[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    vdi_cmp u_cmp (
        .i_stored (w_rd_vtx),
        .i_probe  (r_vtx),
        .i_words  (r_n),
        .o_match  (w_match)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit_now || !w_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_re   = 1'b0;
        w_we   = 1'b0;
        w_load = 1'b0;
        case (r_state)
            S_SCAN: begin
                w_re = !w_hit_now && w_more;
            end
            S_DONE: begin
                w_load = w_out_free;
                w_we   = w_out_free && !r_hit && !w_full;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_words_in_use <= NW_RESET;
            r_count        <= '0;
            r_pos          <= '0;
            r_rd_pend      <= 1'b0;
            r_hit          <= 1'b0;
            r_ov           <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_words_in_use_we) begin
                r_words_in_use <= i_words_in_use;
            end
            if (w_accept) begin
                r_rd_pend <= 1'b0;
                r_hit     <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_rd_pend <= w_re;
                if (w_hit_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (w_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_load) begin
                r_ov <= 1'b1;
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n    <= w_n;
            r_scan <= '0;
            for (int w = 0; w < MAX_WORDS; w++) begin
                r_vtx[w] <= (NW_W'(w) < w_n) ? w_in_vtx[w] : '0;
            end
        end
        if (w_re) begin
            r_scan   <= r_scan + CNT_W'(1);
            r_rd_idx <= r_scan[IDX_W-1:0];
        end
        if ((r_state == S_SCAN) && w_hit_now) begin
            r_hit_idx <= r_rd_idx;
        end
        if (w_load) begin
            r_o_new   <= !r_hit && !w_full;
            r_o_full  <= w_full;
            r_o_pos   <= r_pos;
            if (r_hit) begin
                r_o_index <= r_hit_idx;
            end else if (w_full) begin
                r_o_index <= '0;
            end else begin
                r_o_index <= r_count[IDX_W-1:0];
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_vertex_index  = r_o_index;
    assign o_was_new       = r_o_new;
    assign o_table_full    = r_o_full;
    assign o_list_position = r_o_pos;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("vertex count beyond store depth");

    a_write_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_DONE) && !r_hit && (r_count != COUNT_MAX))
        else $error("store written outside of a miss completion");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |-> (r_state == S_SCAN) && (r_scan < r_count))
        else $error("store read beyond stored vertices");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_was_new && o_table_full))
        else $error("result both new and full");

    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_IDLE) && r_ov)
        else $error("completion did not return to idle with a result");

endmodule

@@ hdl/vdi_ram.sv @@
// ----------------------------------------------------------------------------
// vdi_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module vdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/vdi_cmp.sv @@
// ----------------------------------------------------------------------------
// vdi_cmp
// bitwise compare of a stored vertex with the probe over the active words
// ----------------------------------------------------------------------------
module vdi_cmp (
    input  vdi_pkg::t_vertex              i_stored,
    input  vdi_pkg::t_vertex              i_probe,
    input  logic [vdi_pkg::NW_W-1:0]      i_words,
    output logic                          o_match
);
    import vdi_pkg::*;

    logic [MAX_WORDS-1:0] w_word_ok;

    always_comb begin
        for (int w = 0; w < MAX_WORDS; w++) begin
            w_word_ok[w] = (NW_W'(w) >= i_words) || (i_stored[w] == i_probe[w]);
        end
    end

    assign o_match = &w_word_ok;

endmodule
